[src/dtf_pkg.sv]
// Package for the decimal text to fixed-point parser.
// Holds the request types, parse phases, sequencer states and range constants.
// Depends on nothing; used by decimal_text_to_fixed.
`default_nettype none

package dtf_pkg;

  // Number format and parse limits.
  localparam int unsigned MAX_DIGITS     = 18;
  localparam int unsigned FRAC_BITS      = 32;
  localparam int unsigned FRAC_DIGIT_CAP = 31;
  localparam int unsigned DROP_CAP       = 1023;
  localparam int unsigned EXP_CAP        = 999;
  localparam int unsigned DIV_SHIFT_CAP  = 40;

  // Range limits of the magnitude, by sign.
  localparam logic [63:0] LIM_POS     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_NEG     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] LIM_DIV10   = 64'd922337203685477580;
  localparam logic [63:0] LIM_POS_INT = LIM_POS >> FRAC_BITS;
  localparam logic [63:0] LIM_NEG_INT = LIM_NEG >> FRAC_BITS;

  // Reciprocal of ten for a 20-bit dividend: q = (x * RECIP10) >> RECIP10_SHIFT.
  localparam logic [39:0] RECIP10       = 40'd838861;
  localparam int unsigned RECIP10_SHIFT = 23;

  // ASCII codes.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_MALFORMED = 2'd1;
  localparam logic [1:0] STATUS_SATURATED = 2'd2;

  typedef enum logic [3:0] {
    PH_SKIP,
    PH_SIGN,
    PH_INT,
    PH_FRAC,
    PH_ESTART,
    PH_ESIGN,
    PH_EDIG,
    PH_DONE,
    PH_FAIL
  } parse_phase_e;

  typedef enum logic [2:0] {
    SEQ_PARSE,
    SEQ_MUL,
    SEQ_DIV,
    SEQ_FINISH,
    SEQ_OUT
  } seq_state_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [63:0] value;
  } out_req_t;

endpackage

`default_nettype wire

[src/decimal_text_to_fixed.sv]
// Top level of the decimal text to fixed-point parser.
// Uses dtf_pkg for types and constants; instantiates no other module.
//
// Usage:
//   The input channel (in_valid_i, in_stall_o, in_req_i) takes one ASCII
//   character per request. A request with last set closes the buffer and
//   produces exactly one result on the output channel (out_valid_o,
//   out_stall_i, out_req_o): a status and a signed Q32.32 value.
//   Characters without last produce nothing and do not stall the input.
//   After a last character the input stalls while one shared unit scales
//   the significand by a power of ten:
//     positive exponent e: e multiplies by ten, then a range check,
//     negative exponent k (k up to 40): k steps, in each of which eight 16-bit
//     limbs of the 128-bit word pass the divide-by-ten unit, then a range check,
//     zero significand, malformed text or k above 40: no scaling.
//   The result then sits in the output register until out_stall_i is low;
//   the input stays stalled until the result is taken.
//   Reset clears the parser to the blank-skipping phase and drops any
//   result that was waiting.
`default_nettype none

module decimal_text_to_fixed (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire dtf_pkg::in_req_t in_req_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output dtf_pkg::out_req_t     out_req_o
);

  // Parse state.
  dtf_pkg::parse_phase_e phase_q, phase_d, p_phase;
  logic [59:0] sig_q, sig_d, p_sig;
  logic [4:0]  kept_q, kept_d, p_kept;
  logic [4:0]  frac_q, frac_d, p_frac;
  logic [9:0]  drop_q, drop_d, p_drop;
  logic [9:0]  exp_q, exp_d, p_exp;
  logic        neg_q, neg_d, p_neg;
  logic        eneg_q, eneg_d, p_eneg;

  // Sequencer and shared scaling unit.
  dtf_pkg::seq_state_e state_q, state_d;
  logic              wneg_q, wneg_d;
  logic [63:0]       mag_q, mag_d;
  logic [127:0]      acc_q, acc_d;
  logic [3:0]        rem_q, rem_d;
  logic [11:0]       cnt_q, cnt_d;
  logic [2:0]        limb_q, limb_d;
  dtf_pkg::out_req_t res_q, res_d;

  // Character decode.
  logic [7:0]  ch;
  logic [3:0]  dval;
  logic        is_dig, is_blank, is_sign, is_exp, is_point;
  logic [63:0] sig_mac;
  logic [13:0] exp_mac;
  logic        in_acc, p_ok;
  logic [12:0] e_sum, k_sum;
  logic [63:0] lim, lim_int;
  logic [19:0] div_x, div_qx10;
  logic [39:0] div_prod;
  logic [15:0] div_q;

  assign in_stall_o  = (state_q != dtf_pkg::SEQ_PARSE);
  assign out_valid_o = (state_q == dtf_pkg::SEQ_OUT);
  assign out_req_o   = res_q;
  assign in_acc      = in_valid_i && !in_stall_o;

  // Character classes and digit accumulation.
  always_comb begin
    ch       = in_req_i.char_code;
    dval     = ch[3:0];
    is_dig   = (ch >= dtf_pkg::CH_ZERO) && (ch <= dtf_pkg::CH_NINE);
    is_blank = (ch == dtf_pkg::CH_SPACE) || (ch == dtf_pkg::CH_TAB);
    is_sign  = (ch == dtf_pkg::CH_PLUS) || (ch == dtf_pkg::CH_MINUS);
    is_exp   = (ch == dtf_pkg::CH_E_LO) || (ch == dtf_pkg::CH_E_UP);
    is_point = (ch == dtf_pkg::CH_POINT);
    sig_mac  = {1'b0, sig_q, 3'b000} + {3'b000, sig_q, 1'b0} + {60'd0, dval};
    exp_mac  = {1'b0, exp_q, 3'b000} + {3'b000, exp_q, 1'b0} + {10'd0, dval};
  end

  // Parser step for the incoming character.
  always_comb begin
    p_phase = phase_q;
    p_sig   = sig_q;
    p_kept  = kept_q;
    p_frac  = frac_q;
    p_drop  = drop_q;
    p_exp   = exp_q;
    p_neg   = neg_q;
    p_eneg  = eneg_q;
    unique case (phase_q)
      dtf_pkg::PH_SKIP, dtf_pkg::PH_SIGN, dtf_pkg::PH_INT: begin
        if (is_dig) begin
          // Leading zeros are not significant digits.
          if (!(sig_q == '0 && dval == 4'd0)) begin
            if (kept_q < 5'(dtf_pkg::MAX_DIGITS)) begin
              p_sig  = sig_mac[59:0];
              p_kept = kept_q + 5'd1;
            end else if (drop_q < 10'(dtf_pkg::DROP_CAP)) begin
              p_drop = drop_q + 10'd1;
            end
          end
          p_phase = dtf_pkg::PH_INT;
        end else if (phase_q == dtf_pkg::PH_SKIP) begin
          if (is_sign) begin
            p_neg   = (ch == dtf_pkg::CH_MINUS);
            p_phase = dtf_pkg::PH_SIGN;
          end else if (!is_blank) begin
            p_phase = dtf_pkg::PH_FAIL;
          end
        end else if (phase_q == dtf_pkg::PH_SIGN) begin
          p_phase = dtf_pkg::PH_FAIL;
        end else if (is_point) begin
          p_phase = dtf_pkg::PH_FRAC;
        end else if (is_exp) begin
          p_phase = dtf_pkg::PH_ESTART;
        end else begin
          p_phase = dtf_pkg::PH_DONE;
        end
      end
      dtf_pkg::PH_FRAC: begin
        if (is_dig) begin
          if (kept_q < 5'(dtf_pkg::MAX_DIGITS) &&
              frac_q < 5'(dtf_pkg::FRAC_DIGIT_CAP)) begin
            p_sig  = sig_mac[59:0];
            p_frac = frac_q + 5'd1;
            if (sig_mac != '0) begin
              p_kept = kept_q + 5'd1;
            end
          end
        end else if (is_exp) begin
          p_phase = dtf_pkg::PH_ESTART;
        end else begin
          p_phase = dtf_pkg::PH_DONE;
        end
      end
      dtf_pkg::PH_ESTART, dtf_pkg::PH_ESIGN: begin
        if (phase_q == dtf_pkg::PH_ESTART && is_sign) begin
          p_eneg  = (ch == dtf_pkg::CH_MINUS);
          p_phase = dtf_pkg::PH_ESIGN;
        end else if (is_dig) begin
          p_exp   = {6'd0, dval};
          p_phase = dtf_pkg::PH_EDIG;
        end else begin
          p_phase = dtf_pkg::PH_FAIL;
        end
      end
      dtf_pkg::PH_EDIG: begin
        if (is_dig) begin
          if (exp_mac > 14'(dtf_pkg::EXP_CAP)) begin
            p_exp = 10'(dtf_pkg::EXP_CAP);
          end else begin
            p_exp = exp_mac[9:0];
          end
        end else begin
          p_phase = dtf_pkg::PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer: parse, scale by a power of ten, hold the result.
  always_comb begin
    phase_d = phase_q;
    sig_d   = sig_q;
    kept_d  = kept_q;
    frac_d  = frac_q;
    drop_d  = drop_q;
    exp_d   = exp_q;
    neg_d   = neg_q;
    eneg_d  = eneg_q;
    state_d = state_q;
    wneg_d  = wneg_q;
    mag_d   = mag_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    limb_d  = limb_q;
    res_d   = res_q;

    p_ok  = (p_phase == dtf_pkg::PH_INT) || (p_phase == dtf_pkg::PH_FRAC) ||
            (p_phase == dtf_pkg::PH_EDIG) || (p_phase == dtf_pkg::PH_DONE);
    e_sum = {3'd0, p_drop} - {8'd0, p_frac};
    e_sum = p_eneg ? (e_sum - {3'd0, p_exp}) : (e_sum + {3'd0, p_exp});
    k_sum = 13'd0 - e_sum;
    lim     = wneg_q ? dtf_pkg::LIM_NEG : dtf_pkg::LIM_POS;
    lim_int = wneg_q ? dtf_pkg::LIM_NEG_INT : dtf_pkg::LIM_POS_INT;

    // Divide-by-ten on one 16-bit limb with the running remainder.
    div_x    = {rem_q, acc_q[127:112]};
    div_prod = {20'd0, div_x} * dtf_pkg::RECIP10;
    div_q    = div_prod[dtf_pkg::RECIP10_SHIFT +: 16];
    div_qx10 = {1'b0, div_q, 3'b000} + {3'b000, div_q, 1'b0};

    unique case (state_q)
      dtf_pkg::SEQ_PARSE: begin
        if (in_acc) begin
          if (in_req_i.last) begin
            // Buffer closed: hand the number to the scaler and restart.
            phase_d = dtf_pkg::PH_SKIP;
            sig_d   = '0;
            kept_d  = '0;
            frac_d  = '0;
            drop_d  = '0;
            exp_d   = '0;
            neg_d   = 1'b0;
            eneg_d  = 1'b0;
            wneg_d  = p_neg;
            rem_d   = '0;
            limb_d  = '0;
            mag_d   = {4'd0, p_sig};
            acc_d   = 128'({68'd0, p_sig}) << dtf_pkg::FRAC_BITS;
            if (!p_ok) begin
              res_d.status = dtf_pkg::STATUS_MALFORMED;
              res_d.value  = '0;
              state_d      = dtf_pkg::SEQ_OUT;
            end else if (p_sig == '0 ||
                         (e_sum[12] && k_sum[11:0] > 12'(dtf_pkg::DIV_SHIFT_CAP))) begin
              res_d.status = dtf_pkg::STATUS_OK;
              res_d.value  = '0;
              state_d      = dtf_pkg::SEQ_OUT;
            end else if (!e_sum[12]) begin
              cnt_d   = e_sum[11:0];
              state_d = dtf_pkg::SEQ_MUL;
            end else begin
              cnt_d   = k_sum[11:0];
              state_d = dtf_pkg::SEQ_DIV;
            end
          end else begin
            phase_d = p_phase;
            sig_d   = p_sig;
            kept_d  = p_kept;
            frac_d  = p_frac;
            drop_d  = p_drop;
            exp_d   = p_exp;
            neg_d   = p_neg;
            eneg_d  = p_eneg;
          end
        end
      end
      dtf_pkg::SEQ_MUL: begin
        // One multiply by ten per cycle with an overflow check first.
        if (cnt_q == '0) begin
          if (mag_q > lim_int) begin
            res_d.status = dtf_pkg::STATUS_SATURATED;
            res_d.value  = lim;
          end else begin
            res_d.status = dtf_pkg::STATUS_OK;
            res_d.value  = wneg_q ? (64'd0 - (mag_q << dtf_pkg::FRAC_BITS))
                                  : (mag_q << dtf_pkg::FRAC_BITS);
          end
          state_d = dtf_pkg::SEQ_OUT;
        end else if (mag_q > dtf_pkg::LIM_DIV10) begin
          res_d.status = dtf_pkg::STATUS_SATURATED;
          res_d.value  = lim;
          state_d      = dtf_pkg::SEQ_OUT;
        end else begin
          mag_d = {mag_q[60:0], 3'b000} + {mag_q[62:0], 1'b0};
          cnt_d = cnt_q - 12'd1;
        end
      end
      dtf_pkg::SEQ_DIV: begin
        // The word rotates left one limb per cycle; quotients enter at the bottom.
        acc_d  = {acc_q[111:0], div_q};
        rem_d  = 4'(div_x - div_qx10);
        limb_d = limb_q + 3'd1;
        if (limb_q == 3'd7) begin
          rem_d = '0;
          cnt_d = cnt_q - 12'd1;
          if (cnt_q == 12'd1) begin
            state_d = dtf_pkg::SEQ_FINISH;
          end
        end
      end
      dtf_pkg::SEQ_FINISH: begin
        if (acc_q[127:64] != '0 || acc_q[63:0] > lim) begin
          res_d.status = dtf_pkg::STATUS_SATURATED;
          res_d.value  = lim;
        end else begin
          res_d.status = dtf_pkg::STATUS_OK;
          res_d.value  = wneg_q ? (64'd0 - acc_q[63:0]) : acc_q[63:0];
        end
        state_d = dtf_pkg::SEQ_OUT;
      end
      dtf_pkg::SEQ_OUT: begin
        if (!out_stall_i) begin
          state_d = dtf_pkg::SEQ_PARSE;
        end
      end
      default: begin
        state_d = dtf_pkg::SEQ_PARSE;
      end
    endcase
  end

  // Control and parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtf_pkg::SEQ_PARSE;
      phase_q <= dtf_pkg::PH_SKIP;
      sig_q   <= '0;
      kept_q  <= '0;
      frac_q  <= '0;
      drop_q  <= '0;
      exp_q   <= '0;
      neg_q   <= 1'b0;
      eneg_q  <= 1'b0;
      cnt_q   <= '0;
      limb_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      sig_q   <= sig_d;
      kept_q  <= kept_d;
      frac_q  <= frac_d;
      drop_q  <= drop_d;
      exp_q   <= exp_d;
      neg_q   <= neg_d;
      eneg_q  <= eneg_d;
      cnt_q   <= cnt_d;
      limb_q  <= limb_d;
    end
  end

  // Datapath registers of the scaler and the result.
  always_ff @(posedge clk_i) begin
    wneg_q <= wneg_d;
    mag_q  <= mag_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
  end

endmodule

`default_nettype wire

[verif/dtf_checker.sv]
// Checker for the decimal text to fixed-point parser: watches both channels,
// predicts each result from the accepted characters and compares field by field.
// Depends on dtf_pkg for the request types, parse phases and range constants.
`timescale 1ns / 100ps

module dtf_checker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_stall_i,
  input  wire dtf_pkg::in_req_t  in_req_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_stall_i,
  input  wire dtf_pkg::out_req_t out_req_i,
  output int                     error_count_o,
  output int                     numbers_waiting_o,
  output int                     ok_count_o,
  output int                     malformed_count_o,
  output int                     saturated_count_o
);
  import dtf_pkg::*;

  // Shadow copy of the parser state.
  parse_phase_e phase;
  logic [63:0]  digits_val;
  int unsigned  kept_n;
  int unsigned  frac_n;
  int unsigned  dropped_n;
  int unsigned  exp_mag;
  logic         negative_num;
  logic         negative_exp;

  // Numbers predicted but not yet seen on the output, oldest first.
  out_req_t pending_numbers[$];
  out_req_t want;

  function automatic void clear_number();
    phase        = PH_SKIP;
    digits_val   = '0;
    kept_n       = 0;
    frac_n       = 0;
    dropped_n    = 0;
    exp_mag      = 0;
    negative_num = 1'b0;
    negative_exp = 1'b0;
  endfunction

  // Leading zeros are not significant; digits past the limit only move the exponent.
  function automatic void take_int_digit(input logic [3:0] d);
    if (digits_val == 0 && d == 0) return;
    if (kept_n < MAX_DIGITS) begin
      digits_val = digits_val * 10 + d;
      kept_n++;
    end else if (dropped_n < DROP_CAP) begin
      dropped_n++;
    end
  endfunction

  // Fraction digits past the digit limit or the fraction cap are dropped.
  function automatic void take_frac_digit(input logic [3:0] d);
    if (kept_n >= MAX_DIGITS || frac_n >= FRAC_DIGIT_CAP) return;
    digits_val = digits_val * 10 + d;
    frac_n++;
    if (digits_val != 0) kept_n++;
  endfunction

  function automatic void absorb_char(input logic [7:0] c);
    logic       is_dig;
    logic [3:0] d;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    d      = 4'(c - CH_ZERO);
    case (phase)
      PH_SKIP: begin
        if (c == CH_PLUS || c == CH_MINUS) begin
          negative_num = (c == CH_MINUS);
          phase = PH_SIGN;
        end else if (is_dig) begin
          take_int_digit(d);
          phase = PH_INT;
        end else if (c != CH_SPACE && c != CH_TAB) begin
          phase = PH_FAIL;
        end
      end
      PH_SIGN: begin
        if (is_dig) begin
          take_int_digit(d);
          phase = PH_INT;
        end else begin
          phase = PH_FAIL;
        end
      end
      PH_INT: begin
        if (is_dig) take_int_digit(d);
        else if (c == CH_POINT) phase = PH_FRAC;
        else if (c == CH_E_LO || c == CH_E_UP) phase = PH_ESTART;
        else phase = PH_DONE;
      end
      PH_FRAC: begin
        if (is_dig) take_frac_digit(d);
        else if (c == CH_E_LO || c == CH_E_UP) phase = PH_ESTART;
        else phase = PH_DONE;
      end
      PH_ESTART, PH_ESIGN: begin
        if (phase == PH_ESTART && (c == CH_PLUS || c == CH_MINUS)) begin
          negative_exp = (c == CH_MINUS);
          phase = PH_ESIGN;
        end else if (is_dig) begin
          exp_mag = d;
          phase = PH_EDIG;
        end else begin
          phase = PH_FAIL;
        end
      end
      PH_EDIG: begin
        if (is_dig) begin
          exp_mag = exp_mag * 10 + d;
          if (exp_mag > EXP_CAP) exp_mag = EXP_CAP;
        end else begin
          phase = PH_DONE;
        end
      end
      default: ;
    endcase
  endfunction

  // Magnitude of sig * 10^e in fixed point, truncated; lim with sat set on overflow.
  function automatic logic [63:0] scaled_magnitude(input logic [63:0] sig, input int e,
                                                   input logic [63:0] lim, output logic sat);
    logic [127:0] wide;
    logic [63:0]  m;
    int           i;
    sat = 1'b0;
    if (sig == 0) return 64'd0;
    if (e >= 0) begin
      m = sig;
      for (i = 0; i < e; i++) begin
        if (m > lim / 10) begin
          sat = 1'b1;
          return lim;
        end
        m = m * 10;
      end
      if (m > (lim >> FRAC_BITS)) begin
        sat = 1'b1;
        return lim;
      end
      return m << FRAC_BITS;
    end
    if (-e > int'(DIV_SHIFT_CAP)) return 64'd0;
    // Repeated truncating division by ten equals one division by the power.
    wide = {64'd0, sig} << FRAC_BITS;
    for (i = 0; i < -e; i++) wide = wide / 10;
    if (wide[127:64] != 0 || wide[63:0] > lim) begin
      sat = 1'b1;
      return lim;
    end
    return wide[63:0];
  endfunction

  function automatic out_req_t finished_number();
    out_req_t    res;
    int          e;
    logic [63:0] lim;
    logic [63:0] mag;
    logic        sat;
    res.status = STATUS_MALFORMED;
    res.value  = '0;
    if (phase == PH_INT || phase == PH_FRAC || phase == PH_EDIG || phase == PH_DONE) begin
      e = int'(dropped_n) - int'(frac_n);
      e = negative_exp ? e - int'(exp_mag) : e + int'(exp_mag);
      lim = negative_num ? LIM_NEG : LIM_POS;
      mag = scaled_magnitude(digits_val, e, lim, sat);
      res.value  = negative_num ? -mag : mag;
      res.status = sat ? STATUS_SATURATED : STATUS_OK;
    end
    return res;
  endfunction

  // Sample at the falling edge: a request seen here is taken at the next rising edge.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      clear_number();
      pending_numbers.delete();
      error_count_o     = 0;
      ok_count_o        = 0;
      malformed_count_o = 0;
      saturated_count_o = 0;
    end else begin
      // Results first, so a number is compared before the next buffer starts.
      if (out_valid_i && !out_stall_i) begin
        if (pending_numbers.size() == 0) begin
          $error("unexpected result: status %0d, value %0d",
                 out_req_i.status, out_req_i.value);
          error_count_o++;
        end else begin
          want = pending_numbers.pop_front();
          if (out_req_i.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_req_i.status);
            error_count_o++;
          end
          if (out_req_i.value !== want.value) begin
            $error("value: expected %0d, actual %0d", want.value, out_req_i.value);
            error_count_o++;
          end
        end
        case (out_req_i.status)
          STATUS_OK:        ok_count_o++;
          STATUS_MALFORMED: malformed_count_o++;
          STATUS_SATURATED: saturated_count_o++;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        absorb_char(in_req_i.char_code);
        if (in_req_i.last) begin
          pending_numbers.insert(pending_numbers.size(), finished_number());
          clear_number();
        end
      end
    end
    numbers_waiting_o = pending_numbers.size();
  end

endmodule

[verif/tb_top.sv]
// Top of the decimal text to fixed-point regression: clock, reset and stimulus.
// Depends on dtf_pkg, decimal_text_to_fixed and dtf_checker, which predicts and compares.
`timescale 1ns / 100ps

module tb_top;
  import dtf_pkg::*;

  localparam int unsigned RANDOM_CHARS = 1750;
  localparam int unsigned IDLE_PCT     = 32;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  in_req_t  in_req    = '0;
  logic     in_stall;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_req;

  logic        tx_idle_on = 1'b1;
  logic        rx_idle_on = 1'b1;
  logic        hold_req   = 1'b0;
  int unsigned chars_sent   = 0;
  int unsigned buffers_sent = 0;
  logic [7:0]  text_q[$];

  int error_count;
  int numbers_waiting;
  int ok_count;
  int malformed_count;
  int saturated_count;

  always #6 clk_i = ~clk_i;

  decimal_text_to_fixed u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req)
  );

  dtf_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .in_req_i          (in_req),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .out_req_i         (out_req),
    .error_count_o     (error_count),
    .numbers_waiting_o (numbers_waiting),
    .ok_count_o        (ok_count),
    .malformed_count_o (malformed_count),
    .saturated_count_o (saturated_count)
  );

  // Add one character at the end of the text being built.
  function automatic void append_char(input logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  // Offer one character request and return at the edge where it is taken.
  task automatic send_char(input logic [7:0] code, input logic is_last);
    while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= '{char_code: code, last: is_last};
    @(negedge clk_i);
    while (in_stall) @(negedge clk_i);
    @(posedge clk_i);
    chars_sent++;
  endtask

  task automatic send_buffer();
    foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
    buffers_sent++;
  endtask

  task automatic send_string(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) append_char(s[i]);
    send_buffer();
  endtask

  function automatic void push_digits(input int unsigned n);
    repeat (n) append_char(CH_ZERO + 8'($urandom_range(9)));
  endfunction

  // A well-formed number with random content and an optional tail.
  function automatic void build_number();
    int unsigned pick;
    text_q.delete();
    repeat ($urandom_range(2)) append_char($urandom_range(1) ? CH_SPACE : CH_TAB);
    pick = $urandom_range(2);
    if (pick == 1) append_char(CH_PLUS);
    else if (pick == 2) append_char(CH_MINUS);
    // Integer part: mostly short, sometimes past the digit limit.
    if ($urandom_range(99) < 10) repeat ($urandom_range(1, 4)) append_char(CH_ZERO);
    pick = $urandom_range(99);
    if (pick < 85) push_digits($urandom_range(1, 6));
    else if (pick < 97) push_digits($urandom_range(7, 25));
    else push_digits($urandom_range(26, 60));
    if ($urandom_range(1)) begin
      append_char(CH_POINT);
      if ($urandom_range(99) < 80) push_digits($urandom_range(0, 8));
      else push_digits($urandom_range(9, 36));
    end
    // Exponents stay small mostly; large ones make the block slow.
    if ($urandom_range(99) < 40) begin
      append_char($urandom_range(1) ? CH_E_LO : CH_E_UP);
      pick = $urandom_range(2);
      if (pick == 1) append_char(CH_PLUS);
      else if (pick == 2) append_char(CH_MINUS);
      if ($urandom_range(99) < 90) push_digits($urandom_range(1, 2));
      else push_digits($urandom_range(3, 4));
    end
    if ($urandom_range(1)) begin
      case ($urandom_range(3))
        0: append_char(CH_SPACE);
        1: append_char(CH_TAB);
        2: append_char(8'h0D);
        default: append_char(8'($urandom_range(255)));
      endcase
      repeat ($urandom_range(3)) append_char(8'($urandom_range(255)));
    end
  endfunction

  // A number cut short or with one character swapped for a grammar character or a random byte.
  function automatic void break_number();
    int unsigned cut;
    build_number();
    cut = $urandom_range(text_q.size() - 1);
    if ($urandom_range(1)) begin
      while (text_q.size() > cut + 1) void'(text_q.pop_back());
    end else begin
      case ($urandom_range(5))
        0: text_q[cut] = CH_POINT;
        1: text_q[cut] = CH_E_LO;
        2: text_q[cut] = CH_PLUS;
        3: text_q[cut] = CH_MINUS;
        4: text_q[cut] = CH_SPACE;
        default: text_q[cut] = 8'($urandom_range(255));
      endcase
    end
  endfunction

  function automatic void build_noise();
    text_q.delete();
    repeat ($urandom_range(1, 5)) append_char(8'($urandom_range(255)));
  endfunction

  // Receiver: random stalls, or one long hold counted here when asked.
  initial begin : receiver
    int unsigned hold_cycles;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++) begin
          out_stall <= 1'b1;
          @(posedge clk_i);
        end
      end else begin
        out_stall <= rx_idle_on && ($urandom_range(99) < IDLE_PCT);
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned directed_chars;
    logic        hold_done;
    logic        pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: blank buffer, stray NUL, bare sign, leading point, exponent
    // mark at the end, trailing point, zero with exponent, overflow, -2^31.
    send_string(" ");
    text_q = '{8'h00};
    send_buffer();
    send_string("-");
    send_string(".5");
    send_string("1E");
    send_string("1.");
    send_string("0e9");
    send_string("9e9");
    send_string("-2147483648");
    directed_chars = chars_sent;

    // Random buffers: mostly well-formed, the rest broken or noise.
    while (chars_sent - directed_chars < RANDOM_CHARS) begin
      // A stretch with no idling on either side.
      tx_idle_on = !(chars_sent >= 600 && chars_sent < 900);
      rx_idle_on = tx_idle_on;
      if (!hold_done && chars_sent >= 1100) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      // Pause once until every result has drained.
      if (!pause_done && chars_sent >= 1400) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
        while (numbers_waiting != 0) @(posedge clk_i);
        pause_done = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 70) build_number();
      else if (pick < 85) break_number();
      else build_noise();
      send_buffer();
    end
    in_valid <= 1'b0;

    while (numbers_waiting != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d characters in %0d buffers; results: %0d ok, %0d malformed, %0d saturated.",
             chars_sent, buffers_sent, ok_count, malformed_count, saturated_count);
    $display("Covered blanks, signs, fractions, exponents, overflow, noise, a long hold and a drain.");
    if (error_count == 0) begin
      $display("decimal_text_to_fixed regression: pass");
    end else begin
      $display("decimal_text_to_fixed regression: fail");
    end
    $finish;
  end

  // Watchdog: several times the slowest expected run.
  initial begin : watchdog
    #48_000_000;
    $display("decimal_text_to_fixed regression: fail");
    $finish;
  end

endmodule

[sim.f]
src/dtf_pkg.sv
src/decimal_text_to_fixed.sv
verif/dtf_checker.sv
verif/tb_top.sv
